### hdl/ptt_lpp_pkg.sv
// Shared types and constants for the push-to-talk link parser and prober
`default_nettype none
package ptt_lpp_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_INCOMPLETE = 8'h4C;  // 'L'
    localparam logic [BYTE_W-1:0] CH_OFF        = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_ON         = 8'h31;  // '1'

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic CFG_IDLE_PERIOD = 1'b0;
    localparam logic CFG_PROBE_LIMIT = 1'b1;

    localparam logic [BYTE_W-1:0] IDLE_PERIOD_RST = 8'd10;
    localparam logic [BYTE_W-1:0] PROBE_LIMIT_RST = 8'd3;

    typedef struct packed {
        logic ptt_changed;
        logic ptt_level;
        logic send_probe;
        logic link_lost;
        logic bad_byte;
    } t_result;

    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] value;
    } t_idle_load;

endpackage
`default_nettype wire

### hdl/ptt_lpp_modred.sv
// Bit-serial reduction of the idle count modulo a newly written idle period
`default_nettype none
module ptt_lpp_modred (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ptt_lpp_pkg::BYTE_W-1:0] i_count,
    input  wire logic [ptt_lpp_pkg::BYTE_W-1:0] i_period,
    output logic                           o_busy,
    output ptt_lpp_pkg::t_idle_load        o_load
);
    import ptt_lpp_pkg::*;

    localparam int unsigned STEP_W = $clog2(BYTE_W);

    logic              r_busy,  n_busy;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [BYTE_W-1:0] r_num,   n_num;
    logic [BYTE_W:0]   r_rem,   n_rem;
    logic [BYTE_W:0]   r_div,   n_div;
    logic              r_done,  n_done;
    logic [BYTE_W:0]   shifted;

    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_num   = r_num;
        n_rem   = r_rem;
        n_div   = r_div;
        n_done  = 1'b0;
        shifted = {r_rem[BYTE_W-1:0], r_num[BYTE_W-1]};
        if (i_start) begin
            // a zero period counts as 256
            n_busy = 1'b1;
            n_step = '0;
            n_num  = i_count;
            n_rem  = '0;
            n_div  = (i_period == '0) ? {1'b1, {BYTE_W{1'b0}}} : {1'b0, i_period};
        end else if (r_busy) begin
            n_num = {r_num[BYTE_W-2:0], 1'b0};
            n_rem = (shifted >= r_div) ? shifted - r_div : shifted;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(BYTE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy       = r_busy || r_done;
    assign o_load.load  = r_done;
    assign o_load.value = r_rem[BYTE_W-1:0];

endmodule
`default_nettype wire

### hdl/ptt_lpp_core.sv
// Parser and prober state with the single-pass step logic
`default_nettype none
module ptt_lpp_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_adv,
    input  wire logic                           i_mode,
    input  wire logic [ptt_lpp_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic [ptt_lpp_pkg::BYTE_W-1:0] i_idle_period,
    input  wire logic [ptt_lpp_pkg::BYTE_W-1:0] i_probe_limit,
    input  wire ptt_lpp_pkg::t_idle_load        i_idle_load,
    output logic [ptt_lpp_pkg::BYTE_W-1:0]      o_idle_count,
    output ptt_lpp_pkg::t_result                o_result
);
    import ptt_lpp_pkg::*;

    logic              r_complete, n_complete;
    logic              r_seen,     n_seen;
    logic              r_reported, n_reported;
    logic [BYTE_W-1:0] r_idle,     n_idle;
    logic [BYTE_W-1:0] r_probes,   n_probes;
    logic [BYTE_W:0]   idle_inc;
    logic [BYTE_W:0]   period;
    t_result           res;

    always_comb begin
        n_complete = r_complete;
        n_seen     = r_seen;
        n_reported = r_reported;
        n_idle     = r_idle;
        n_probes   = r_probes;
        res        = '0;
        idle_inc   = {1'b0, r_idle} + 1'b1;
        period     = (i_idle_period == '0) ? {1'b1, {BYTE_W{1'b0}}}
                                           : {1'b0, i_idle_period};
        if (i_mode == MODE_BYTE) begin
            n_probes = '0;
            case (i_rx_byte)
                CH_INCOMPLETE: n_complete = 1'b0;
                CH_OFF: begin
                    n_complete = 1'b1;
                    n_seen     = 1'b0;
                end
                CH_ON: begin
                    n_complete = 1'b1;
                    n_seen     = 1'b1;
                end
                default: res.bad_byte = 1'b1;
            endcase
            if (n_complete && (n_seen != r_reported)) begin
                n_reported      = n_seen;
                res.ptt_changed = 1'b1;
            end
        end else if (r_probes > i_probe_limit) begin
            res.link_lost = 1'b1;
        end else begin
            // idle count is kept below the period, so one compare wraps it
            n_idle = (idle_inc == period) ? '0 : idle_inc[BYTE_W-1:0];
            if (n_idle == '0) begin
                res.send_probe = 1'b1;
                if (r_probes != '1) begin
                    n_probes = r_probes + 1'b1;
                end
            end
        end
        res.ptt_level = n_reported;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complete <= 1'b0;
            r_seen     <= 1'b0;
            r_reported <= 1'b0;
            r_idle     <= '0;
            r_probes   <= '0;
        end else if (i_idle_load.load) begin
            r_idle <= i_idle_load.value;
        end else if (i_adv) begin
            r_complete <= n_complete;
            r_seen     <= n_seen;
            r_reported <= n_reported;
            r_idle     <= n_idle;
            r_probes   <= n_probes;
        end
    end

    assign o_idle_count = r_idle;
    assign o_result     = res;

endmodule
`default_nettype wire

### hdl/ptt_link_parser_prober_top.sv
// Top level: input register, step logic, result register and configuration
// An accepted word is held in the input register, stepped, and shown from the result register.
// Throughput: one word per cycle while the output is not stalled and no reduction runs;
// input and result registers decouple the ports. An idle_period write starts a bit-serial
// reduction of the idle counter, then loads it; input words are held off until the load.
// Synchronous active-low reset clears state, counters and valids; registers go to 10 and 3.
`default_nettype none
module ptt_link_parser_prober_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_ptt_changed,
    output logic            o_ptt_level,
    output logic            o_send_probe,
    output logic            o_link_lost,
    output logic            o_bad_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import ptt_lpp_pkg::*;

    logic              r_in_valid;
    logic              r_in_mode;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_idle_period;
    logic [BYTE_W-1:0] r_probe_limit;

    logic              adv;
    logic              cfg_wr;
    logic              red_start;
    logic              red_busy;
    t_idle_load        idle_load;
    logic [BYTE_W-1:0] idle_count;
    t_result           step_res;

    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign red_start = cfg_wr && (i_cfg_index == CFG_IDLE_PERIOD);
    assign adv       = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !red_busy && (!r_in_valid || adv);
    assign o_cfg_ready = 1'b1;

    ptt_lpp_modred u_modred (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (red_start),
        .i_count  (idle_count),
        .i_period (i_cfg_data),
        .o_busy   (red_busy),
        .o_load   (idle_load)
    );

    ptt_lpp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_mode        (r_in_mode),
        .i_rx_byte     (r_in_byte),
        .i_idle_period (r_idle_period),
        .i_probe_limit (r_probe_limit),
        .i_idle_load   (idle_load),
        .o_idle_count  (idle_count),
        .o_result      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_idle_period <= IDLE_PERIOD_RST;
            r_probe_limit <= PROBE_LIMIT_RST;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (i_cfg_index == CFG_IDLE_PERIOD) begin
                    r_idle_period <= i_cfg_data;
                end else begin
                    r_probe_limit <= i_cfg_data;
                end
            end
        end
        if (i_valid && o_ready) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_rx_byte;
        end
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ptt_changed = r_out.ptt_changed;
    assign o_ptt_level   = r_out.ptt_level;
    assign o_send_probe  = r_out.send_probe;
    assign o_link_lost   = r_out.link_lost;
    assign o_bad_byte    = r_out.bad_byte;

endmodule
`default_nettype wire

### hdl/ptt_lpp_checker.sv
// Port-level checker for the parser and prober, bound to the top level
`default_nettype none
module ptt_lpp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_ptt_changed,
    input wire logic o_ptt_level,
    input wire logic o_send_probe,
    input wire logic o_link_lost,
    input wire logic o_bad_byte
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ptt_level)
            && $stable(o_ptt_changed) && $stable(o_send_probe)
            && $stable(o_link_lost) && $stable(o_bad_byte))
        else $error("result word changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // byte results never carry tick flags
    a_byte_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ptt_changed || o_bad_byte) |-> !o_send_probe && !o_link_lost)
        else $error("byte result carries tick flags");

    a_bad_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_byte |-> !o_ptt_changed)
        else $error("bad byte flipped the level");

    a_probe_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_probe |-> !o_link_lost)
        else $error("probe sent with link lost");

endmodule

bind ptt_link_parser_prober_top ptt_lpp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ptt_changed (o_ptt_changed),
    .o_ptt_level   (o_ptt_level),
    .o_send_probe  (o_send_probe),
    .o_link_lost   (o_link_lost),
    .o_bad_byte    (o_bad_byte)
);
`default_nettype wire
